FILE: hw/rtl/assert_macros.svh
// assertion macros used by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: hw/rtl/slcd_pkg.sv
// types and constants for the sync/length/crc packet deframer
`timescale 1ns / 1ps

package slcd_pkg;

    localparam int SLOT_BYTES_DEF = 1024;
    localparam int SLOTS_DEF      = 8;

    localparam int LEN_W = 11;
    localparam int CNT_W = 3;

    localparam logic [7:0]       SYNC_BYTE       = 8'hA5;
    localparam logic [15:0]      CRC_POLY        = 16'h1021;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 11'd1024;
    localparam logic [CNT_W-1:0] MAX_PACKETS_RST = 3'd5;

    localparam logic REG_MAX_LENGTH  = 1'b0;
    localparam logic REG_MAX_PACKETS = 1'b1;

    typedef enum logic [1:0] {
        REQ_RX    = 2'd0,
        REQ_READ  = 2'd1,
        REQ_ABORT = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_CRC_DROP = 3'd2,
        ST_LEN_DROP = 3'd3,
        ST_ACC_DROP = 3'd4,
        ST_READ     = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    typedef struct packed {
        req_t       req_type;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [LEN_W-1:0] frame_length;
        logic [CNT_W-1:0] frames_stored;
    } result_t;

endpackage

FILE: hw/rtl/sync_length_crc_packet_deframer.sv
// sync/length/crc packet deframer with a ring of stored frames
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each beat on the item channel is a received byte, a read of the next byte of
// the oldest stored frame, or an abort of the frame being received. Every beat
// produces exactly one result beat, the cycle after it is taken, and a new beat
// is taken in every cycle while the result side keeps up (one item per cycle).
// The frame store is a single-port RAM of SLOTS * SLOT_BYTES bytes: a received
// payload byte writes it and a read beat reads it in the same cycle the beat is
// taken, and the registered read data forms part of the result register, so a
// stalled result holds its data byte. The store needs no clearing after reset;
// only bytes of complete frames are ever read back. The crc update is an
// eight-step bit loop on 16 bits in front of the crc register.
module sync_length_crc_packet_deframer
    import slcd_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int SLOTS      = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,

    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = SLOTS * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [3:0]        SLOT_LIM  = 4'(SLOTS - 1);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // frame store and slot length table
    logic [7:0]       store_mem [DEPTH];
    logic [LEN_W-1:0] slot_len_mem [SLOTS];

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] rx_index_reg, rx_index_next;
    logic [LEN_W-1:0] rx_length_reg, rx_length_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] read_index_reg, read_index_next;
    logic [LEN_W-1:0] head_len_reg, head_len_next;
    logic [LEN_W-1:0] max_length_reg;
    logic [CNT_W-1:0] max_packets_reg;

    logic             res_valid_reg, res_valid_next;
    status_t          res_status_reg, res_status_next;
    logic             res_hit_reg, res_hit_next;
    logic             res_last_reg, res_last_next;
    logic [LEN_W-1:0] res_flen_reg, res_flen_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;
    logic [7:0]       mem_q_reg;

    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic              slot_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] fill_inc;
    logic [3:0]        limit;
    logic [3:0]        count_inc;
    logic [15:0]       len_rx;
    logic [LEN_W:0]    rx_index_inc;
    logic [LEN_W:0]    read_index_inc;

    assign accept     = item_valid && item_ready;
    assign item_ready = !res_valid_reg || result_ready;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign fill_inc = (fill_reg == LAST_SLOT) ? '0 : fill_reg + 1'b1;

    assign len_rx         = {crc_high_reg, item.rx_byte};
    assign rx_index_inc   = {1'b0, rx_index_reg} + 1'b1;
    assign read_index_inc = {1'b0, read_index_reg} + 1'b1;
    assign count_inc      = {1'b0, count_reg} + 1'b1;

    // one address for both the write and the read of the single-port store
    always_comb
    begin
        if (item.req_type == REQ_RX)
        begin
            mem_addr = ADDR_W'(fill_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rx_index_reg);
        end
        else
        begin
            mem_addr = ADDR_W'(head_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_index_reg);
        end
    end

    always_comb
    begin
        limit = {1'b0, max_packets_reg};
        if (limit == 4'd0)
        begin
            limit = 4'd1;
        end
        if (limit > SLOT_LIM)
        begin
            limit = SLOT_LIM;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        rx_index_next   = rx_index_reg;
        rx_length_next  = rx_length_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        read_index_next = read_index_reg;
        head_len_next   = head_len_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_last_next   = res_last_reg;
        res_flen_next   = res_flen_reg;
        res_count_next  = res_count_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        slot_we         = 1'b0;

        if (accept)
        begin
            res_status_next = ST_NONE;
            res_hit_next    = 1'b0;
            res_last_next   = 1'b0;

            case (item.req_type)
                REQ_RX:
                begin
                    unique case (phase_reg)
                        PH_SYNC1:
                        begin
                            phase_next = (item.rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
                        end
                        PH_SYNC2:
                        begin
                            phase_next = (item.rx_byte == SYNC_BYTE) ? PH_LEN_HI : PH_SYNC1;
                        end
                        PH_LEN_HI:
                        begin
                            if (item.rx_byte != SYNC_BYTE)
                            begin
                                crc_high_next = item.rx_byte;
                                phase_next    = PH_LEN_LO;
                            end
                        end
                        PH_LEN_LO:
                        begin
                            if (len_rx > {5'd0, max_length_reg} || len_rx > 16'(SLOT_BYTES))
                            begin
                                phase_next      = PH_SYNC1;
                                rx_index_next   = '0;
                                rx_length_next  = '0;
                                crc_next        = '0;
                                crc_high_next   = '0;
                                res_status_next = ST_LEN_DROP;
                            end
                            else
                            begin
                                rx_length_next = len_rx[LEN_W-1:0];
                                rx_index_next  = '0;
                                crc_next       = '0;
                                crc_high_next  = '0;
                                phase_next     = (len_rx == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            mem_we        = 1'b1;
                            crc_next      = crc_step(crc_reg, item.rx_byte);
                            rx_index_next = rx_index_inc[LEN_W-1:0];
                            if (rx_index_inc >= {1'b0, rx_length_reg})
                            begin
                                phase_next = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI:
                        begin
                            crc_high_next = item.rx_byte;
                            phase_next    = PH_CRC_LO;
                        end
                        PH_CRC_LO:
                        begin
                            phase_next     = PH_SYNC1;
                            rx_index_next  = '0;
                            rx_length_next = '0;
                            crc_next       = '0;
                            crc_high_next  = '0;
                            if (len_rx != crc_reg)
                            begin
                                res_status_next = ST_CRC_DROP;
                            end
                            else
                            begin
                                slot_we   = 1'b1;
                                fill_next = fill_inc;
                                if (count_reg == '0)
                                begin
                                    head_len_next = rx_length_reg;
                                end
                                if (count_inc > limit)
                                begin
                                    // oldest frame dropped, partial read restarts
                                    head_next       = head_inc;
                                    count_next      = count_reg;
                                    read_index_next = '0;
                                    head_len_next   = (head_inc == fill_reg) ?
                                                      rx_length_reg : slot_len_mem[head_inc];
                                    res_status_next = ST_ACC_DROP;
                                end
                                else
                                begin
                                    count_next      = count_inc[CNT_W-1:0];
                                    res_status_next = ST_ACCEPT;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next     = PH_SYNC1;
                            rx_index_next  = '0;
                            rx_length_next = '0;
                            crc_next       = '0;
                            crc_high_next  = '0;
                        end
                    endcase
                end
                REQ_READ:
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        res_status_next = ST_READ;
                        if (read_index_reg < head_len_reg)
                        begin
                            mem_re       = 1'b1;
                            res_hit_next = 1'b1;
                        end
                        read_index_next = read_index_inc[LEN_W-1:0];
                        if (read_index_inc >= {1'b0, head_len_reg})
                        begin
                            head_next       = head_inc;
                            count_next      = count_reg - 1'b1;
                            read_index_next = '0;
                            head_len_next   = slot_len_mem[head_inc];
                            res_last_next   = 1'b1;
                        end
                    end
                end
                REQ_ABORT:
                begin
                    phase_next     = PH_SYNC1;
                    rx_index_next  = '0;
                    rx_length_next = '0;
                    crc_next       = '0;
                    crc_high_next  = '0;
                end
                default:
                begin
                end
            endcase

            res_valid_next = 1'b1;
            res_count_next = count_next;
            res_flen_next  = (count_next != '0) ? head_len_next : '0;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            rx_index_reg    <= '0;
            rx_length_reg   <= '0;
            crc_reg         <= '0;
            crc_high_reg    <= '0;
            head_reg        <= '0;
            fill_reg        <= '0;
            count_reg       <= '0;
            read_index_reg  <= '0;
            head_len_reg    <= '0;
            max_length_reg  <= MAX_LENGTH_RST;
            max_packets_reg <= MAX_PACKETS_RST;
            res_valid_reg   <= 1'b0;
            res_status_reg  <= ST_NONE;
            res_hit_reg     <= 1'b0;
            res_last_reg    <= 1'b0;
            res_flen_reg    <= '0;
            res_count_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            rx_index_reg   <= rx_index_next;
            rx_length_reg  <= rx_length_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            read_index_reg <= read_index_next;
            head_len_reg   <= head_len_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
            res_last_reg   <= res_last_next;
            res_flen_reg   <= res_flen_next;
            res_count_reg  <= res_count_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    REG_MAX_LENGTH:  max_length_reg  <= pwdata[LEN_W-1:0];
                    REG_MAX_PACKETS: max_packets_reg <= pwdata[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= item.rx_byte;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[mem_addr];
        end
        if (slot_we)
        begin
            slot_len_mem[fill_reg] <= rx_length_reg;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {29'd0, max_packets_reg} : {21'd0, max_length_reg};

    assign result_valid         = res_valid_reg;
    assign result.status        = res_status_reg;
    assign result.data_byte     = res_hit_reg ? mem_q_reg : 8'd0;
    assign result.last_byte     = res_last_reg;
    assign result.frame_length  = res_flen_reg;
    assign result.frames_stored = res_count_reg;

    `ASSERT_PROP(a_count_bound, clk, rst_n, {1'b0, count_reg} <= SLOT_LIM)
    `ASSERT_PROP(a_payload_index, clk, rst_n, phase_reg != PH_PAYLOAD || rx_index_reg < rx_length_reg)
    `ASSERT_PROP(a_last_is_read, clk, rst_n, !(res_valid_reg && res_last_reg) || res_status_reg == ST_READ)
    `ASSERT_NEVER(a_hit_not_read, clk, rst_n, res_hit_reg && res_status_reg != ST_READ)

endmodule
